[hdl/rtcsc_pkg.sv]
// Package for the RTC seconds counter: command and register codes, constants.
`default_nettype none
package rtcsc_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_CTRL_LOW   = 3'd0,
    REG_CTRL_HIGH  = 3'd1,
    REG_CNT_HIGH   = 3'd2,
    REG_CNT_LOW    = 3'd3,
    REG_ALARM_HIGH = 3'd4,
    REG_ALARM_LOW  = 3'd5
  } reg_idx_t;

  // ctrl_low / ctrl_high bit positions
  localparam int CTRL_SECF_BIT  = 0;
  localparam int CTRL_ALRF_BIT  = 1;
  localparam int CTRL_SYNC_BIT  = 3;
  localparam int CTRL_CNF_BIT   = 4;
  localparam int CTRL_DONE_BIT  = 5;
  localparam int CTRL_ALRIE_BIT = 1;

  localparam logic [19:0] PRESCALER_RESET = 20'd32768;
  localparam logic [31:0] ALARM_RESET     = 32'hFFFF_FFFF;

  // count / 3600 = (count >> 4) / 225, via reciprocal 2^35 / 225 plus one correction
  localparam logic [27:0] HOUR_RECIP    = 28'd152709948;
  localparam int          HOUR_SHIFT    = 35;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;

  // rem / 60 exact for rem < 3600 with reciprocal 4370 / 2^18
  localparam logic [12:0] MIN_RECIP = 13'd4370;
  localparam int          MIN_SHIFT = 18;

endpackage
`default_nettype wire

[hdl/rtcsc_if.sv]
// Request and result channel interfaces of the RTC seconds counter.
`default_nettype none
interface rtcsc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [2:0]  reg_index;
  logic [15:0] write_data;

  modport source (output valid, output cmd, output reg_index, output write_data,
                  input ready);
  modport sink   (input valid, input cmd, input reg_index, input write_data,
                  output ready);
endinterface

interface rtcsc_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic [20:0] hours;
  logic [5:0]  minutes;
  logic [5:0]  secs;
  logic        alarm_irq;

  modport source (output valid, output read_data, output hours, output minutes,
                  output secs, output alarm_irq, input ready);
  modport sink   (input valid, input read_data, input hours, input minutes,
                  input secs, input alarm_irq, output ready);
endinterface
`default_nettype wire

[hdl/rtc_seconds_counter_alarm_top.sv]
// RTC seconds counter with alarm: register state and time-split result pipeline.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-------------------------------------------
//  req     | in  | valid / ready    | cmd, reg_index, write_data
//  rsp     | out | valid / ready    | read_data, hours, minutes, secs, alarm_irq
//  cfg     | in  | cfg_we           | cfg_wdata (prescaler reload)
//
// One request per cycle while req is ready; the state updates in the cycle the
// request is taken. Its result passes five register stages (s1, s2, s3, s4,
// out); the hours/minutes/seconds split sets the depth (reciprocal multiply,
// remainder, correction, minute split).
// rst is synchronous: clears state (alarm to all ones), prescaler reload 32768.
// A stalled rsp holds; empty stages keep filling, so req stays ready until
// all five stages are full.
`default_nettype none
module rtc_seconds_counter_alarm_top
  import rtcsc_pkg::*;
#(
  parameter int DIVIDER_BITS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  rtcsc_req_if.sink        req,
  rtcsc_rsp_if.source      rsp,
  input  wire logic        cfg_we,
  input  wire logic [19:0] cfg_wdata
);

  logic [19:0]             prescaler_reload;
  logic [31:0]             seconds_count, seconds_count_next;
  logic [DIVIDER_BITS-1:0] divider, divider_next;
  logic [31:0]             alarm_value, alarm_value_next;
  logic                    config_mode, config_mode_next;
  logic                    alarm_flag, alarm_flag_next;
  logic                    second_flag, second_flag_next;
  logic                    sync_flag, sync_flag_next;
  logic                    alarm_irq_enable, alarm_irq_enable_next;
  logic [15:0]             rd_next;
  logic [DIVIDER_BITS-1:0] reload_val;
  logic [31:0]             count_inc;
  logic                    req_fire;

  // pipeline stages
  logic        v1, v2, v3, v4, vo;
  logic        en1, en2, en3, en4, eno;
  logic [31:0] s1_count, s2_count;
  logic [15:0] s1_rd, s2_rd, s3_rd, s4_rd;
  logic        s1_irq, s2_irq, s3_irq, s4_irq;
  logic [20:0] s2_q, s3_q, s4_hours;
  logic [12:0] s3_rem;
  logic [11:0] s4_rem;
  logic [55:0] hour_prod;
  logic [31:0] hour_secs, hour_diff;
  logic [24:0] min_prod;
  logic [5:0]  min_val;
  logic [11:0] min_secs, sec_full;
  logic [15:0] out_rd;
  logic [20:0] out_hours;
  logic [5:0]  out_minutes, out_secs;
  logic        out_irq;

  assign eno = !vo || rsp.ready;
  assign en4 = !v4 || eno;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign req.ready = en1;
  assign req_fire  = req.valid && en1;

  assign reload_val = DIVIDER_BITS'(prescaler_reload);
  assign count_inc  = seconds_count + 32'd1;

  always_comb begin
    seconds_count_next    = seconds_count;
    divider_next          = divider;
    alarm_value_next      = alarm_value;
    config_mode_next      = config_mode;
    alarm_flag_next       = alarm_flag;
    second_flag_next      = second_flag;
    sync_flag_next        = sync_flag;
    alarm_irq_enable_next = alarm_irq_enable;
    rd_next               = 16'd0;
    case (cmd_t'(req.cmd))
      CMD_TICK: begin
        sync_flag_next = 1'b1;
        if (!config_mode) begin
          if (divider == '0) begin
            divider_next       = reload_val;
            seconds_count_next = count_inc;
            second_flag_next   = 1'b1;
            if (count_inc == alarm_value) alarm_flag_next = 1'b1;
          end else begin
            divider_next = divider - DIVIDER_BITS'(1);
          end
        end
      end
      CMD_READ: begin
        case (reg_idx_t'(req.reg_index))
          REG_CTRL_LOW: begin
            rd_next[CTRL_SECF_BIT] = second_flag;
            rd_next[CTRL_ALRF_BIT] = alarm_flag;
            rd_next[CTRL_SYNC_BIT] = sync_flag;
            rd_next[CTRL_CNF_BIT]  = config_mode;
            rd_next[CTRL_DONE_BIT] = 1'b1;
          end
          REG_CTRL_HIGH:  rd_next[CTRL_ALRIE_BIT] = alarm_irq_enable;
          REG_CNT_HIGH:   rd_next = seconds_count[31:16];
          REG_CNT_LOW:    rd_next = seconds_count[15:0];
          REG_ALARM_HIGH: rd_next = alarm_value[31:16];
          REG_ALARM_LOW:  rd_next = alarm_value[15:0];
          default:        rd_next = 16'd0;
        endcase
      end
      CMD_WRITE: begin
        case (reg_idx_t'(req.reg_index))
          REG_CTRL_LOW: begin
            if (!req.write_data[CTRL_SECF_BIT]) second_flag_next = 1'b0;
            if (!req.write_data[CTRL_ALRF_BIT]) alarm_flag_next  = 1'b0;
            if (!req.write_data[CTRL_SYNC_BIT]) sync_flag_next   = 1'b0;
            config_mode_next = req.write_data[CTRL_CNF_BIT];
          end
          REG_CTRL_HIGH: alarm_irq_enable_next = req.write_data[CTRL_ALRIE_BIT];
          REG_CNT_HIGH: begin
            if (config_mode) seconds_count_next[31:16] = req.write_data;
          end
          REG_CNT_LOW: begin
            if (config_mode) seconds_count_next[15:0] = req.write_data;
          end
          REG_ALARM_HIGH: begin
            if (config_mode) alarm_value_next[31:16] = req.write_data;
          end
          REG_ALARM_LOW: begin
            if (config_mode) alarm_value_next[15:0] = req.write_data;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescaler_reload <= PRESCALER_RESET;
    end else if (cfg_we) begin
      prescaler_reload <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_count    <= 32'd0;
      divider          <= '0;
      alarm_value      <= ALARM_RESET;
      config_mode      <= 1'b0;
      alarm_flag       <= 1'b0;
      second_flag      <= 1'b0;
      sync_flag        <= 1'b0;
      alarm_irq_enable <= 1'b0;
    end else if (req_fire) begin
      seconds_count    <= seconds_count_next;
      divider          <= divider_next;
      alarm_value      <= alarm_value_next;
      config_mode      <= config_mode_next;
      alarm_flag       <= alarm_flag_next;
      second_flag      <= second_flag_next;
      sync_flag        <= sync_flag_next;
      alarm_irq_enable <= alarm_irq_enable_next;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (en1) v1 <= req.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (eno) vo <= v4;
    end
  end

  assign hour_prod = s1_count[31:4] * HOUR_RECIP;
  assign hour_secs = 32'(s2_q) * 32'(SECS_PER_HOUR);
  assign hour_diff = s2_count - hour_secs;
  assign min_prod  = 25'(s4_rem) * 25'(MIN_RECIP);
  assign min_val   = min_prod[MIN_SHIFT+5:MIN_SHIFT];
  assign min_secs  = {min_val, 6'd0} - {4'd0, min_val, 2'd0};
  assign sec_full  = s4_rem - min_secs;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_count <= seconds_count_next;
      s1_rd    <= rd_next;
      s1_irq   <= alarm_flag_next && alarm_irq_enable_next;
    end
    if (en2) begin
      s2_count <= s1_count;
      s2_q     <= hour_prod[HOUR_SHIFT+20:HOUR_SHIFT];
      s2_rd    <= s1_rd;
      s2_irq   <= s1_irq;
    end
    if (en3) begin
      s3_q   <= s2_q;
      s3_rem <= hour_diff[12:0];
      s3_rd  <= s2_rd;
      s3_irq <= s2_irq;
    end
    if (en4) begin
      if (s3_rem >= 13'(SECS_PER_HOUR)) begin
        s4_hours <= s3_q + 21'd1;
        s4_rem   <= 12'(s3_rem - 13'(SECS_PER_HOUR));
      end else begin
        s4_hours <= s3_q;
        s4_rem   <= s3_rem[11:0];
      end
      s4_rd  <= s3_rd;
      s4_irq <= s3_irq;
    end
    if (eno) begin
      out_rd      <= s4_rd;
      out_hours   <= s4_hours;
      out_minutes <= min_val;
      out_secs    <= sec_full[5:0];
      out_irq     <= s4_irq;
    end
  end

  assign rsp.valid     = vo;
  assign rsp.read_data = out_rd;
  assign rsp.hours     = out_hours;
  assign rsp.minutes   = out_minutes;
  assign rsp.secs      = out_secs;
  assign rsp.alarm_irq = out_irq;

endmodule
`default_nettype wire

[hdl/rtcsc_checker.sv]
// Port-level checks for the RTC seconds counter, bound to the top level.
`default_nettype none
module rtcsc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        valid,
  input wire logic        ready,
  input wire logic [15:0] read_data,
  input wire logic [20:0] hours,
  input wire logic [5:0]  minutes,
  input wire logic [5:0]  secs,
  input wire logic        alarm_irq
);

  a_rst_empty: assert property (@(posedge clk) $past(rst) |-> !valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(read_data) && $stable(hours) &&
      $stable(minutes) && $stable(secs) && $stable(alarm_irq))
    else $error("stalled result changed");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> secs < 6'd60 && minutes < 6'd60 && hours <= 21'd1193046)
    else $error("time split out of range");

endmodule

bind rtc_seconds_counter_alarm_top rtcsc_checker u_rtcsc_checker (
  .clk       (clk),
  .rst       (rst),
  .valid     (rsp.valid),
  .ready     (rsp.ready),
  .read_data (rsp.read_data),
  .hours     (rsp.hours),
  .minutes   (rsp.minutes),
  .secs      (rsp.secs),
  .alarm_irq (rsp.alarm_irq)
);
`default_nettype wire
